/* hdl/dczts_pkg.sv */
package dczts_pkg;

    // screen size defaults in pixels
    localparam int SCREEN_WIDTH_DEF  = 256;
    localparam int SCREEN_HEIGHT_DEF = 240;

    // field widths
    localparam int POS_W   = 16;
    localparam int DZ_W    = 8;
    localparam int TILES_W = 10;
    localparam int ADDR_W  = 14;
    localparam int CTRL_W  = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // nametable and control constants
    localparam logic [ADDR_W-1:0] NT_BASE      = 14'h2000;
    localparam logic [ADDR_W-1:0] NT_COL_HIGH  = 14'h2400;
    localparam logic [ADDR_W-1:0] NT_ROW_HIGH  = 14'h2800;
    localparam logic [CTRL_W-1:0] CTRL_BASE_NMI = 8'h90;
    localparam logic [CTRL_W-1:0] CTRL_BASE     = 8'h10;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WIN_LEFT      = 3'd0,
        REG_WIN_RIGHT     = 3'd1,
        REG_WIN_TOP       = 3'd2,
        REG_WIN_BOTTOM    = 3'd3,
        REG_WORLD_COLUMNS = 3'd4,
        REG_WORLD_ROWS    = 3'd5,
        REG_NMI_ENABLE    = 3'd6
    } cfg_reg_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [DZ_W-1:0]    win_left;
        logic [DZ_W-1:0]    win_right;
        logic [DZ_W-1:0]    win_top;
        logic [DZ_W-1:0]    win_bottom;
        logic [TILES_W-1:0] world_columns;
        logic [TILES_W-1:0] world_rows;
        logic               nmi_enable;
    } cfg_t;

    // nametable address of a column top
    function automatic logic [ADDR_W-1:0] column_addr_f(input logic [TILES_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        base = idx[5] ? NT_COL_HIGH : NT_BASE;
        return base + {9'b0, idx[4:0]};
    endfunction

    // nametable address of a row start
    function automatic logic [ADDR_W-1:0] row_addr_f(input logic [TILES_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        base = idx[5] ? NT_ROW_HIGH : NT_BASE;
        return base + {4'b0, idx[4:0], 5'b0};
    endfunction

endpackage

/* hdl/dczts_cfg.sv */
module dczts_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dczts_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dczts_pkg::CFG_DATA_W-1:0]    cfg_data,
    output dczts_pkg::cfg_t                     cfg
);

    dczts_pkg::cfg_t cfg_reg;
    dczts_pkg::cfg_t cfg_next;

    // register writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register decode, masked to each register's width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (dczts_pkg::cfg_reg_t'(cfg_index))
                dczts_pkg::REG_WIN_LEFT:      cfg_next.win_left      = cfg_data[7:0];
                dczts_pkg::REG_WIN_RIGHT:     cfg_next.win_right     = cfg_data[7:0];
                dczts_pkg::REG_WIN_TOP:       cfg_next.win_top       = cfg_data[7:0];
                dczts_pkg::REG_WIN_BOTTOM:    cfg_next.win_bottom    = cfg_data[7:0];
                dczts_pkg::REG_WORLD_COLUMNS: cfg_next.world_columns = cfg_data;
                dczts_pkg::REG_WORLD_ROWS:    cfg_next.world_rows    = cfg_data;
                dczts_pkg::REG_NMI_ENABLE:    cfg_next.nmi_enable    = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_left      <= '0;
            cfg_reg.win_right     <= '0;
            cfg_reg.win_top       <= '0;
            cfg_reg.win_bottom    <= '0;
            cfg_reg.world_columns <= 10'd32;
            cfg_reg.world_rows    <= 10'd30;
            cfg_reg.nmi_enable    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/dczts_axis.sv */
module dczts_axis
#(
    parameter int SCREEN = dczts_pkg::SCREEN_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [dczts_pkg::POS_W-1:0]       target,
    input  logic [dczts_pkg::DZ_W-1:0]        lo,
    input  logic [dczts_pkg::DZ_W-1:0]        hi,
    input  logic [dczts_pkg::TILES_W-1:0]     tiles,
    output logic [dczts_pkg::POS_W-1:0]       cam,
    output logic                              line_valid,
    output logic [dczts_pkg::TILES_W-1:0]     line_index
);

    localparam logic [13:0] SCREEN_C = 14'(SCREEN);
    localparam logic [16:0] LEAD_C   = 17'(SCREEN - 8);

    logic [15:0] cam_reg;
    logic [15:0] cam_next;
    logic [15:0] base_reg;
    logic [15:0] base_next;

    logic [13:0] world;
    logic [15:0] max_pos;
    logic [16:0] edge_lo;
    logic [16:0] edge_hi;
    logic [16:0] tgt_w;
    logic [15:0] lo_w;
    logic [15:0] hi_w;
    logic [15:0] follow;
    logic [16:0] lead;
    logic [13:0] idx;
    logic        moved;

    // largest camera position
    assign world   = {1'b0, tiles, 3'b000};
    assign max_pos = (world > SCREEN_C) ? {2'b0, world - SCREEN_C} : '0;

    // deadzone follow
    assign lo_w    = {8'b0, lo};
    assign hi_w    = {8'b0, hi};
    assign tgt_w   = {1'b0, target};
    assign edge_lo = {1'b0, cam_reg} + {9'b0, lo};
    assign edge_hi = {1'b0, cam_reg} + {9'b0, hi};
    assign follow  = target - hi_w;

    always_comb
    begin
        if (tgt_w < edge_lo)
        begin
            cam_next = (target < lo_w) ? '0 : target - lo_w;
        end
        else if (tgt_w > edge_hi)
        begin
            cam_next = (follow > max_pos) ? max_pos : follow;
        end
        else
        begin
            cam_next = cam_reg;
        end
    end

    // streamer baseline steps one tile toward the camera
    always_comb
    begin
        moved     = 1'b0;
        base_next = base_reg;
        lead      = '0;
        idx       = '0;
        if (cam_next[15:3] != base_reg[15:3])
        begin
            moved = 1'b1;
            if (cam_next > base_reg)
            begin
                base_next = base_reg + 16'd8;
                lead      = {1'b0, base_next} + LEAD_C;
                idx       = lead[16:3];
            end
            else
            begin
                base_next = base_reg - 16'd8;
                idx       = {1'b0, base_next[15:3]};
            end
        end
    end

    assign cam        = cam_next;
    assign line_valid = moved && (idx < {4'b0, tiles});
    assign line_index = line_valid ? idx[9:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg  <= '0;
            base_reg <= '0;
        end
        else if (en)
        begin
            cam_reg  <= cam_next;
            base_reg <= base_next;
        end
    end

endmodule

/* hdl/deadzone_camera_tile_streamer_core.sv */
// Each accepted input word waits in the input register until the result register is free or
// draining, and its result word is then registered there and shown on the outputs.
// Throughput: one word per cycle while out_stall is low; the camera and streamer state update
// in the compute step between the input register and the result register.
// Reset (rst_n, async, active low) clears camera, baselines and valid flags and
// loads the register defaults (32 columns, 30 rows, deadzone and nmi at zero).
module deadzone_camera_tile_streamer_core
#(
    parameter int SCREEN_WIDTH  = dczts_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = dczts_pkg::SCREEN_HEIGHT_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dczts_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dczts_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input words
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dczts_pkg::POS_W-1:0]         target_x,
    input  logic [dczts_pkg::POS_W-1:0]         target_y,
    // result words
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dczts_pkg::POS_W-1:0]         camera_x,
    output logic [dczts_pkg::POS_W-1:0]         camera_y,
    output logic [dczts_pkg::CTRL_W-1:0]        control_byte,
    output logic                                column_valid,
    output logic [dczts_pkg::TILES_W-1:0]       column_index,
    output logic [dczts_pkg::ADDR_W-1:0]        column_address,
    output logic                                row_valid,
    output logic [dczts_pkg::TILES_W-1:0]       row_index,
    output logic [dczts_pkg::ADDR_W-1:0]        row_address
);

    dczts_pkg::cfg_t cfg;

    logic        in_vld_reg;
    logic        in_vld_next;
    logic [15:0] tx_reg;
    logic [15:0] ty_reg;
    logic        out_vld_reg;
    logic        out_vld_next;
    logic        advance;
    logic        in_take;

    logic [15:0] cam_x;
    logic [15:0] cam_y;
    logic        col_vld;
    logic [9:0]  col_idx;
    logic        row_vld;
    logic [9:0]  row_idx;
    logic [7:0]  ctrl;

    logic [15:0] camera_x_reg;
    logic [15:0] camera_y_reg;
    logic [7:0]  control_byte_reg;
    logic        column_valid_reg;
    logic [9:0]  column_index_reg;
    logic [13:0] column_address_reg;
    logic        row_valid_reg;
    logic [9:0]  row_index_reg;
    logic [13:0] row_address_reg;

    dczts_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // handshake: compute when the result register is free or draining
    assign advance      = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall     = in_vld_reg && !advance;
    assign in_take      = in_valid && !in_stall;
    assign in_vld_next  = in_take || (in_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && out_stall);

    dczts_axis #(.SCREEN(SCREEN_WIDTH)) u_axis_x
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .target     (tx_reg),
        .lo         (cfg.win_left),
        .hi         (cfg.win_right),
        .tiles      (cfg.world_columns),
        .cam        (cam_x),
        .line_valid (col_vld),
        .line_index (col_idx)
    );

    dczts_axis #(.SCREEN(SCREEN_HEIGHT)) u_axis_y
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .target     (ty_reg),
        .lo         (cfg.win_top),
        .hi         (cfg.win_bottom),
        .tiles      (cfg.world_rows),
        .cam        (cam_y),
        .line_valid (row_vld),
        .line_index (row_idx)
    );

    // scroll control byte
    assign ctrl = (cfg.nmi_enable ? dczts_pkg::CTRL_BASE_NMI : dczts_pkg::CTRL_BASE)
                | {6'b0, cam_y[8], cam_x[8]};

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // input word register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tx_reg <= target_x;
            ty_reg <= target_y;
        end
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            camera_x_reg       <= cam_x;
            camera_y_reg       <= cam_y;
            control_byte_reg   <= ctrl;
            column_valid_reg   <= col_vld;
            column_index_reg   <= col_idx;
            column_address_reg <= col_vld ? dczts_pkg::column_addr_f(col_idx) : '0;
            row_valid_reg      <= row_vld;
            row_index_reg      <= row_idx;
            row_address_reg    <= row_vld ? dczts_pkg::row_addr_f(row_idx) : '0;
        end
    end

    assign out_valid      = out_vld_reg;
    assign camera_x       = camera_x_reg;
    assign camera_y       = camera_y_reg;
    assign control_byte   = control_byte_reg;
    assign column_valid   = column_valid_reg;
    assign column_index   = column_index_reg;
    assign column_address = column_address_reg;
    assign row_valid      = row_valid_reg;
    assign row_index      = row_index_reg;
    assign row_address    = row_address_reg;

endmodule

/* tb/tb_top.sv */
module tb_top;

    localparam int          SCREEN_W    = dczts_pkg::SCREEN_WIDTH_DEF;
    localparam int          SCREEN_H    = dczts_pkg::SCREEN_HEIGHT_DEF;
    localparam int          IDLE_PCT    = 18;
    localparam int          HOLD_CYCLES = 160;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          RAND_PHASES = 8;
    localparam int          PHASE_WORDS = 210;
    localparam int          PRINT_CAP   = 40;
    localparam logic [dczts_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    // one target word and one predicted scroll word
    typedef struct {
        logic [dczts_pkg::POS_W-1:0] x;
        logic [dczts_pkg::POS_W-1:0] y;
    } target_t;

    typedef struct {
        logic [dczts_pkg::POS_W-1:0]   camera_x;
        logic [dczts_pkg::POS_W-1:0]   camera_y;
        logic [dczts_pkg::CTRL_W-1:0]  control_byte;
        logic                          column_valid;
        logic [dczts_pkg::TILES_W-1:0] column_index;
        logic [dczts_pkg::ADDR_W-1:0]  column_address;
        logic                          row_valid;
        logic [dczts_pkg::TILES_W-1:0] row_index;
        logic [dczts_pkg::ADDR_W-1:0]  row_address;
    } scroll_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [dczts_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [dczts_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [dczts_pkg::POS_W-1:0]       target_x = '0;
    logic [dczts_pkg::POS_W-1:0]       target_y = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [dczts_pkg::POS_W-1:0]       camera_x;
    logic [dczts_pkg::POS_W-1:0]       camera_y;
    logic [dczts_pkg::CTRL_W-1:0]      control_byte;
    logic                              column_valid;
    logic [dczts_pkg::TILES_W-1:0]     column_index;
    logic [dczts_pkg::ADDR_W-1:0]      column_address;
    logic                              row_valid;
    logic [dczts_pkg::TILES_W-1:0]     row_index;
    logic [dczts_pkg::ADDR_W-1:0]      row_address;

    // model state and register copy
    dczts_pkg::cfg_t                   shadow_cfg;
    logic [dczts_pkg::POS_W-1:0]       cam_x, cam_y, base_x, base_y;

    target_t                targets_waiting[$];
    scroll_t                scroll_due[$];

    int                     frames_queued = 0;
    int                     frames_taken = 0;
    int                     frames_checked = 0;
    int                     column_loads = 0;
    int                     row_loads = 0;
    int                     settings_used = 0;
    int                     error_count = 0;
    int                     cycle_count = 0;
    int                     hold_req = 0;
    int                     hold_seen = 0;
    int                     hold_left = 0;
    bit                     no_idle = 1'b0;
    logic                   in_took = 1'b0;

    deadzone_camera_tile_streamer_core u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .target_x       (target_x),
        .target_y       (target_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .camera_x       (camera_x),
        .camera_y       (camera_y),
        .control_byte   (control_byte),
        .column_valid   (column_valid),
        .column_index   (column_index),
        .column_address (column_address),
        .row_valid      (row_valid),
        .row_index      (row_index),
        .row_address    (row_address)
    );

    always #10 clk = ~clk;

    // camera follow on one axis, sums kept wide before the clamp
    function automatic logic [dczts_pkg::POS_W-1:0] follow_axis(
        input logic [dczts_pkg::POS_W-1:0]   cam,
        input logic [dczts_pkg::POS_W-1:0]   tgt,
        input logic [dczts_pkg::DZ_W-1:0]    lo,
        input logic [dczts_pkg::DZ_W-1:0]    hi,
        input logic [dczts_pkg::TILES_W-1:0] tiles,
        input int unsigned                   screen);
        int unsigned span;
        int unsigned cam_max;
        int unsigned win_lo;
        int unsigned win_hi;
        int unsigned pos;
        int unsigned gap;
        span    = 32'(tiles) * 8;
        cam_max = (span > screen) ? span - screen : 0;
        pos     = 32'(cam);
        win_lo  = pos + 32'(lo);
        win_hi  = pos + 32'(hi);
        // window start is tested first
        if (32'(tgt) < win_lo)
        begin
            gap = win_lo - 32'(tgt);
            pos = (gap > pos) ? 0 : pos - gap;
        end
        else if (32'(tgt) > win_hi)
        begin
            pos = pos + (32'(tgt) - win_hi);
            if (pos > cam_max)
                pos = cam_max;
        end
        return pos[dczts_pkg::POS_W-1:0];
    endfunction

    // baseline steps one tile toward the camera and exposes a line
    task automatic advance_line(input logic [dczts_pkg::POS_W-1:0] cam,
                                inout logic [dczts_pkg::POS_W-1:0] base,
                                input int unsigned screen,
                                input logic [dczts_pkg::TILES_W-1:0] tiles,
                                output logic hit,
                                output logic [dczts_pkg::TILES_W-1:0] line);
        int unsigned idx;
        hit  = 1'b0;
        line = '0;
        if (cam[dczts_pkg::POS_W-1:3] != base[dczts_pkg::POS_W-1:3])
        begin
            if (cam > base)
            begin
                base = base + 16'd8;
                idx  = (32'(base) + screen - 8) >> 3;
            end
            else
            begin
                base = base - 16'd8;
                idx  = 32'(base) >> 3;
            end
            if (idx < 32'(tiles))
            begin
                hit  = 1'b1;
                line = idx[dczts_pkg::TILES_W-1:0];
            end
        end
    endtask

    // next scroll word from one target word
    task automatic predict_scroll(input logic [dczts_pkg::POS_W-1:0] tx,
                                  input logic [dczts_pkg::POS_W-1:0] ty,
                                  output scroll_t s);
        logic                          hit;
        logic [dczts_pkg::TILES_W-1:0] line;
        cam_x = follow_axis(cam_x, tx, shadow_cfg.win_left, shadow_cfg.win_right,
                            shadow_cfg.world_columns, SCREEN_W);
        cam_y = follow_axis(cam_y, ty, shadow_cfg.win_top, shadow_cfg.win_bottom,
                            shadow_cfg.world_rows, SCREEN_H);
        s.camera_x = cam_x;
        s.camera_y = cam_y;

        advance_line(cam_x, base_x, SCREEN_W, shadow_cfg.world_columns, hit, line);
        s.column_valid   = hit;
        s.column_index   = hit ? line : '0;
        s.column_address = hit ? (line[5] ? dczts_pkg::NT_COL_HIGH : dczts_pkg::NT_BASE)
                                 + dczts_pkg::ADDR_W'(line[4:0]) : '0;

        advance_line(cam_y, base_y, SCREEN_H, shadow_cfg.world_rows, hit, line);
        s.row_valid   = hit;
        s.row_index   = hit ? line : '0;
        s.row_address = hit ? (line[5] ? dczts_pkg::NT_ROW_HIGH : dczts_pkg::NT_BASE)
                              + dczts_pkg::ADDR_W'({line[4:0], 5'b0}) : '0;

        s.control_byte    = shadow_cfg.nmi_enable ? dczts_pkg::CTRL_BASE_NMI
                                                  : dczts_pkg::CTRL_BASE;
        s.control_byte[0] = cam_x[8];
        s.control_byte[1] = cam_y[8];
    endtask

    task automatic log_error(input string msg);
        if (error_count < PRINT_CAP)
            $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // input driver: a stalled word holds, otherwise offer the next one or idle
    always @(negedge clk)
    begin : drive_targets
        target_t nxt;
        if (rst_n && (!in_valid || in_took))
        begin
            if (targets_waiting.size() > 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                nxt = targets_waiting.pop_front();
                in_valid <= 1'b1;
                target_x <= nxt.x;
                target_y <= nxt.y;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result receiver: random stalls plus a long hold-off on request
    always @(negedge clk)
    begin : drive_stall
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // monitor: check results against the oldest prediction, then predict new words
    always @(posedge clk)
    begin : watch_ports
        scroll_t want;
        in_took <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (scroll_due.size() == 0)
                    log_error("result word with no prediction waiting");
                else
                begin
                    want = scroll_due.pop_front();
                    frames_checked++;
                    if (camera_x !== want.camera_x)
                        log_error($sformatf("camera_x %0d, want %0d", camera_x, want.camera_x));
                    if (camera_y !== want.camera_y)
                        log_error($sformatf("camera_y %0d, want %0d", camera_y, want.camera_y));
                    if (control_byte !== want.control_byte)
                        log_error($sformatf("control_byte %h, want %h",
                                            control_byte, want.control_byte));
                    if (column_valid !== want.column_valid)
                        log_error($sformatf("column_valid %b, want %b",
                                            column_valid, want.column_valid));
                    if (column_index !== want.column_index)
                        log_error($sformatf("column_index %0d, want %0d",
                                            column_index, want.column_index));
                    if (column_address !== want.column_address)
                        log_error($sformatf("column_address %h, want %h",
                                            column_address, want.column_address));
                    if (row_valid !== want.row_valid)
                        log_error($sformatf("row_valid %b, want %b", row_valid, want.row_valid));
                    if (row_index !== want.row_index)
                        log_error($sformatf("row_index %0d, want %0d", row_index, want.row_index));
                    if (row_address !== want.row_address)
                        log_error($sformatf("row_address %h, want %h",
                                            row_address, want.row_address));
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_scroll(target_x, target_y, want);
                column_loads += want.column_valid;
                row_loads    += want.row_valid;
                scroll_due.push_back(want);
                frames_taken++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [dczts_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [dczts_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        // mirror the write, masked to the register width
        case (idx)
            dczts_pkg::REG_WIN_LEFT:
                shadow_cfg.win_left      = val[dczts_pkg::DZ_W-1:0];
            dczts_pkg::REG_WIN_RIGHT:
                shadow_cfg.win_right     = val[dczts_pkg::DZ_W-1:0];
            dczts_pkg::REG_WIN_TOP:
                shadow_cfg.win_top       = val[dczts_pkg::DZ_W-1:0];
            dczts_pkg::REG_WIN_BOTTOM:
                shadow_cfg.win_bottom    = val[dczts_pkg::DZ_W-1:0];
            dczts_pkg::REG_WORLD_COLUMNS:
                shadow_cfg.world_columns = val[dczts_pkg::TILES_W-1:0];
            dczts_pkg::REG_WORLD_ROWS:
                shadow_cfg.world_rows    = val[dczts_pkg::TILES_W-1:0];
            dczts_pkg::REG_NMI_ENABLE:
                shadow_cfg.nmi_enable    = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [9:0] l, input logic [9:0] r, input logic [9:0] t,
                             input logic [9:0] b, input logic [9:0] cols,
                             input logic [9:0] rows, input logic [9:0] nmi);
        write_reg(dczts_pkg::REG_WIN_LEFT, l);
        write_reg(dczts_pkg::REG_WIN_RIGHT, r);
        write_reg(dczts_pkg::REG_WIN_TOP, t);
        write_reg(dczts_pkg::REG_WIN_BOTTOM, b);
        write_reg(dczts_pkg::REG_WORLD_COLUMNS, cols);
        write_reg(dczts_pkg::REG_WORLD_ROWS, rows);
        write_reg(dczts_pkg::REG_NMI_ENABLE, nmi);
        settings_used++;
        @(posedge clk);
    endtask

    task automatic queue_frame(input logic [dczts_pkg::POS_W-1:0] x,
                               input logic [dczts_pkg::POS_W-1:0] y);
        target_t w;
        w.x = x;
        w.y = y;
        targets_waiting.push_back(w);
        frames_queued++;
    endtask

    // sender pause until every predicted word has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (frames_taken != frames_queued || scroll_due.size() != 0);
    endtask

    function automatic int walk_clip(input int v);
        return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
    endfunction

    // smooth target motion with occasional jumps and extremes
    task automatic queue_walk(input int count);
        int px, py, vx, vy, pick;
        px = $urandom_range(0, 32'(shadow_cfg.world_columns) * 8 + 256);
        py = $urandom_range(0, 32'(shadow_cfg.world_rows) * 8 + 240);
        vx = 0;
        vy = 0;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                vx = $urandom_range(0, 16) - 8;
                vy = $urandom_range(0, 16) - 8;
            end
            if (pick < 82)
            begin
                px = walk_clip(px + vx + $urandom_range(0, 4) - 2);
                py = walk_clip(py + vy + $urandom_range(0, 4) - 2);
            end
            else if (pick < 92)
            begin
                px = walk_clip(px + $urandom_range(0, 128) - 64);
                py = walk_clip(py + $urandom_range(0, 128) - 64);
            end
            else if (pick < 97)
            begin
                px = $urandom_range(0, 65535);
                py = $urandom_range(0, 65535);
            end
            else
            begin
                px = $urandom_range(0, 1) ? 65535 : 0;
                py = $urandom_range(0, 1) ? 65535 : 0;
            end
            queue_frame(px[dczts_pkg::POS_W-1:0], py[dczts_pkg::POS_W-1:0]);
        end
    endtask

    function automatic logic [9:0] pick_world();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 10'($urandom_range(1, 40));
        else if (r < 8)
            return 10'($urandom_range(20, 200));
        else if (r < 9)
            return 10'd1023;
        return 10'($urandom_range(0, 1023));
    endfunction

    initial
    begin
        shadow_cfg = '{win_left: '0, win_right: '0, win_top: '0,
                       win_bottom: '0, world_columns: 10'd32, world_rows: 10'd30,
                       nmi_enable: 1'b0};
        cam_x  = '0;
        cam_y  = '0;
        base_x = '0;
        base_y = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, field extremes
        settings_used++;
        queue_frame(16'h0000, 16'h0000);
        queue_frame(16'hFFFF, 16'hFFFF);
        queue_frame(16'h0001, 16'h0001);
        queue_frame(16'h8000, 16'h5555);
        wait_drained();

        // ordinary window: inside, right of it, far right, then back to zero
        write_all(10'd64, 10'd128, 10'd48, 10'd144, 10'd64, 10'd60, 10'd1);
        queue_frame(16'd100, 16'd100);
        queue_frame(16'd200, 16'd200);
        repeat (4) queue_frame(16'hFFFF, 16'hFFFF);
        repeat (3) queue_frame(16'h0000, 16'h0000);
        queue_frame(16'd10, 16'd5);
        wait_drained();

        // window start above window end, widest world
        write_all(10'd200, 10'd50, 10'd220, 10'd30, 10'd1023, 10'd1023, 10'd0);
        queue_frame(16'd150, 16'd150);
        queue_frame(16'd300, 16'd300);
        queue_frame(16'd40, 16'd40);
        wait_drained();

        // camera pushed out, then the world shrinks below the screen
        write_all(10'd0, 10'd0, 10'd0, 10'd0, 10'd128, 10'd128, 10'd1);
        repeat (3) queue_frame(16'hFFFF, 16'hFFFF);
        wait_drained();
        write_reg(dczts_pkg::REG_WORLD_COLUMNS, 10'd20);
        write_reg(dczts_pkg::REG_WORLD_ROWS, 10'd2);
        write_reg(REG_UNUSED, 10'h3FF);
        write_reg(dczts_pkg::REG_WIN_RIGHT, 10'h3FF);
        write_reg(dczts_pkg::REG_WIN_BOTTOM, 10'h3FF);
        settings_used++;
        @(posedge clk);
        queue_frame(16'd600, 16'd600);
        repeat (4) queue_frame(16'h0000, 16'h0000);
        wait_drained();
        write_reg(dczts_pkg::REG_WORLD_COLUMNS, 10'd0);
        write_reg(dczts_pkg::REG_WORLD_ROWS, 10'd0);
        settings_used++;
        @(posedge clk);
        queue_frame(16'd5000, 16'd5000);
        queue_frame(16'h0000, 16'h0000);
        wait_drained();

        // random phases, each under its own settings
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0:       write_all(10'd0, 10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1);
                1:       write_all(10'h3FF, 10'h3FF, 10'd255, 10'd255, 10'd1, 10'd1, 10'd0);
                2:       write_all(10'd96, 10'd160, 10'd80, 10'd160, 10'd64, 10'd60, 10'd1);
                default: write_all(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                                   10'($urandom_range(0, 255)), 10'($urandom_range(0, 255)),
                                   pick_world(), pick_world(), 10'($urandom_range(0, 1023)));
            endcase
            no_idle = (p == 2);
            if (p == 4)
                hold_req++;
            queue_walk(PHASE_WORDS);
            wait_drained();
            no_idle = 1'b0;
        end

        repeat (10) @(posedge clk);
        $display("covered %0d frames (%0d checked) across %0d register settings",
                 frames_taken, frames_checked, settings_used);
        $display("streamed %0d columns and %0d rows", column_loads, row_loads);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
hdl/dczts_pkg.sv
hdl/dczts_cfg.sv
hdl/dczts_axis.sv
hdl/deadzone_camera_tile_streamer_core.sv
tb/tb_top.sv
